>>> hw/rtl/rdiv256_pkg.sv
`default_nettype none

package rdiv256_pkg;

	// Width of one port word.
	localparam int unsigned FIELD_BITS = 64;

	// Width of a two-word operand as seen on the ports.
	localparam int unsigned PAIR_BITS = 2 * FIELD_BITS;

	// Default divisor, quotient and remainder width.
	localparam int unsigned WORD_BITS_DEF = 128;

endpackage

`default_nettype wire

>>> hw/rtl/restoring_divider_256_by_128_core.sv
`default_nettype none

// Unsigned restoring divider: a 2*WORD_BITS-bit dividend {dividend_w3..dividend_w0}
// divided by a WORD_BITS-bit divisor {divisor_hi, divisor_lo}, giving a WORD_BITS-bit
// quotient and remainder. When WORD_BITS is below 128, the operands are the low
// WORD_BITS bits of each port pair and the unused upper result bits read as zero.
// overflow is set when the upper dividend half is not below the divisor (divide by
// zero included); the results are then still what the shift-and-subtract steps give.
// The divider is a pipeline of WORD_BITS stages, one shift-and-subtract step each,
// behind an input register and ahead of an output register, so one division is
// accepted every cycle while in_ready is high. A two-entry output buffer (the output
// register and a skid entry) decouples out_ready from in_ready: once a result fills
// the skid entry behind a stalled consumer, in_ready drops and the pipeline holds.
module restoring_divider_256_by_128_core #(
	parameter int unsigned WORD_BITS = rdiv256_pkg::WORD_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [rdiv256_pkg::FIELD_BITS-1:0] dividend_w3,
	input  wire logic [rdiv256_pkg::FIELD_BITS-1:0] dividend_w2,
	input  wire logic [rdiv256_pkg::FIELD_BITS-1:0] dividend_w1,
	input  wire logic [rdiv256_pkg::FIELD_BITS-1:0] dividend_w0,
	input  wire logic [rdiv256_pkg::FIELD_BITS-1:0] divisor_hi,
	input  wire logic [rdiv256_pkg::FIELD_BITS-1:0] divisor_lo,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic      [rdiv256_pkg::FIELD_BITS-1:0] quotient_hi,
	output logic      [rdiv256_pkg::FIELD_BITS-1:0] quotient_lo,
	output logic      [rdiv256_pkg::FIELD_BITS-1:0] remainder_hi,
	output logic      [rdiv256_pkg::FIELD_BITS-1:0] remainder_lo,
	output logic                                    overflow
);
	import rdiv256_pkg::*;

	localparam int unsigned W = WORD_BITS;

	logic [PAIR_BITS-1:0] x_in;
	logic [PAIR_BITS-1:0] y_in;
	logic [PAIR_BITS-1:0] z_in;

	// Stage 0 is the input register; stage k holds the state after k steps.
	logic [W-1:0] rem_s [0:W];
	logic [W-1:0] quo_s [0:W];
	logic [W-1:0] div_s [0:W];
	logic         ovf_s [0:W];
	logic         vld_s [0:W];

	logic         adv;
	logic         out_take;

	logic [W-1:0] out_quo_q;
	logic [W-1:0] out_rem_q;
	logic         out_ovf_q;
	logic         out_vld_q;
	logic [W-1:0] skid_quo_q;
	logic [W-1:0] skid_rem_q;
	logic         skid_ovf_q;
	logic         skid_vld_q;

	logic [PAIR_BITS-1:0] quo_full;
	logic [PAIR_BITS-1:0] rem_full;

	assign x_in = {dividend_w3, dividend_w2};
	assign y_in = {dividend_w1, dividend_w0};
	assign z_in = {divisor_hi, divisor_lo};

	// The pipeline moves as a whole while the output buffer has a free entry.
	assign adv      = !skid_vld_q;
	assign in_ready = adv;
	assign out_take = out_vld_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			rem_s[0] <= x_in[W-1:0];
			quo_s[0] <= y_in[W-1:0];
			div_s[0] <= z_in[W-1:0];
			ovf_s[0] <= (x_in[W-1:0] >= z_in[W-1:0]);
		end
	end

	for (genvar k = 0; k < W; k++) begin : g_step
		logic         lost;
		logic [W-1:0] shifted;
		logic [W:0]   trial;
		logic         take;

		// The bit shifted out of the top forces the subtraction; with it the
		// partial remainder is 2^W + shifted, always above the divisor.
		assign lost    = rem_s[k][W-1];
		assign shifted = {rem_s[k][W-2:0], quo_s[k][W-1]};
		assign trial   = {lost, shifted} - {1'b0, div_s[k]};
		assign take    = lost || !trial[W];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv && vld_s[k]) begin
				rem_s[k+1] <= take ? trial[W-1:0] : shifted;
				quo_s[k+1] <= {quo_s[k][W-2:0], take};
				div_s[k+1] <= div_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	// Output register with a skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || out_ready) begin
			out_vld_q  <= skid_vld_q || (adv && vld_s[W]);
			skid_vld_q <= 1'b0;
		end else if (adv && vld_s[W]) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || out_ready) begin
			if (skid_vld_q) begin
				out_quo_q <= skid_quo_q;
				out_rem_q <= skid_rem_q;
				out_ovf_q <= skid_ovf_q;
			end else begin
				out_quo_q <= quo_s[W];
				out_rem_q <= rem_s[W];
				out_ovf_q <= ovf_s[W];
			end
		end else if (adv && vld_s[W]) begin
			skid_quo_q <= quo_s[W];
			skid_rem_q <= rem_s[W];
			skid_ovf_q <= ovf_s[W];
		end
	end

	assign quo_full = PAIR_BITS'(out_quo_q);
	assign rem_full = PAIR_BITS'(out_rem_q);

	assign out_valid    = out_vld_q;
	assign quotient_hi  = quo_full[PAIR_BITS-1:FIELD_BITS];
	assign quotient_lo  = quo_full[FIELD_BITS-1:0];
	assign remainder_hi = rem_full[PAIR_BITS-1:FIELD_BITS];
	assign remainder_lo = rem_full[FIELD_BITS-1:0];
	assign overflow     = out_ovf_q;

`ifndef SYNTH
	// The skid entry only fills behind a held output.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry valid while output register empty");

	// A result leaves the skid entry only when the output is taken.
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && !out_take |=> skid_vld_q)
		else $error("skid entry dropped without a transfer");

	// A zero divisor always flags overflow.
	a_div_zero_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] && (div_s[0] == '0) |-> ovf_s[0])
		else $error("zero divisor without overflow");

	// Without overflow, the final remainder is below the divisor.
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[W] && !ovf_s[W] |-> (rem_s[W] < div_s[W]))
		else $error("remainder not below divisor");
`endif

endmodule

`default_nettype wire

>>> test/restoring_divider_256_by_128_core_tb.sv
`default_nettype none

module restoring_divider_256_by_128_core_tb;
	import rdiv256_pkg::*;

	localparam int unsigned WB = WORD_BITS_DEF;
	localparam int unsigned WAIT_MAX = 17;
	localparam int unsigned LATENCY = WB + 2;
	localparam int unsigned IDLE_LIMIT = 4000;

	typedef logic [PAIR_BITS-1:0] pair_t;
	typedef logic [FIELD_BITS-1:0] word_t;

	typedef struct packed {
		word_t quo_hi;
		word_t quo_lo;
		word_t rem_hi;
		word_t rem_lo;
		logic ovf;
	} div_result_t;

	localparam pair_t WORD_MASK = (WB >= PAIR_BITS) ? '1 : ((pair_t'(1) << WB) - 1);
	localparam pair_t ALL_ONES = WORD_MASK;
	localparam pair_t TOP_BIT = pair_t'(1) << (WB - 1);

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	word_t dividend_w3;
	word_t dividend_w2;
	word_t dividend_w1;
	word_t dividend_w0;
	word_t divisor_hi;
	word_t divisor_lo;
	logic out_valid;
	logic out_ready;
	word_t quotient_hi;
	word_t quotient_lo;
	word_t remainder_hi;
	word_t remainder_lo;
	logic overflow;

	div_result_t pending_results[$];
	int unsigned mismatch_count = 0;
	int unsigned sent_count = 0;
	int unsigned checked_count = 0;
	int unsigned overflow_seen = 0;
	int unsigned zero_divisor_count = 0;
	int unsigned idle_cycles = 0;
	bit no_gaps = 1'b0;

	restoring_divider_256_by_128_core #(
		.WORD_BITS(WB)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.dividend_w3(dividend_w3),
		.dividend_w2(dividend_w2),
		.dividend_w1(dividend_w1),
		.dividend_w0(dividend_w0),
		.divisor_hi(divisor_hi),
		.divisor_lo(divisor_lo),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.quotient_hi(quotient_hi),
		.quotient_lo(quotient_lo),
		.remainder_hi(remainder_hi),
		.remainder_lo(remainder_lo),
		.overflow(overflow)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Shift-and-subtract division over WB steps; the bit leaving the top of the
	// partial remainder forces the subtraction.
	function automatic div_result_t divide_restoring(pair_t num_hi, pair_t num_lo, pair_t den);
		pair_t x;
		pair_t y;
		pair_t z;
		logic lost;
		div_result_t r;
		x = num_hi & WORD_MASK;
		y = num_lo & WORD_MASK;
		z = den & WORD_MASK;
		r.ovf = (x >= z);
		for (int i = 0; i < WB; i++) begin
			lost = x[WB-1];
			x = ((x << 1) | pair_t'(y[WB-1])) & WORD_MASK;
			y = (y << 1) & WORD_MASK;
			if (lost || x >= z) begin
				x = (x - z) & WORD_MASK;
				y[0] = 1'b1;
			end
		end
		r.quo_hi = y[PAIR_BITS-1:FIELD_BITS];
		r.quo_lo = y[FIELD_BITS-1:0];
		r.rem_hi = x[PAIR_BITS-1:FIELD_BITS];
		r.rem_lo = x[FIELD_BITS-1:0];
		return r;
	endfunction

	function automatic int unsigned draw_wait();
		return no_gaps ? 0 : $urandom_range(0, WAIT_MAX);
	endfunction

	function automatic pair_t rand_pair();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	// Random value with a random number of leading zeros.
	function automatic pair_t rand_scaled();
		return rand_pair() >> $urandom_range(0, PAIR_BITS - 1);
	endfunction

	task automatic send_division(pair_t num_hi, pair_t num_lo, pair_t den);
		int unsigned gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		dividend_w3 <= num_hi[PAIR_BITS-1:FIELD_BITS];
		dividend_w2 <= num_hi[FIELD_BITS-1:0];
		dividend_w1 <= num_lo[PAIR_BITS-1:FIELD_BITS];
		dividend_w0 <= num_lo[FIELD_BITS-1:0];
		divisor_hi <= den[PAIR_BITS-1:FIELD_BITS];
		divisor_lo <= den[FIELD_BITS-1:0];
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(divide_restoring(num_hi, num_lo, den));
		sent_count++;
		if ((den & WORD_MASK) == '0)
			zero_divisor_count++;
	endtask

	// Well-formed divisions (high half below divisor) but for ovf_pct percent, which are
	// unconstrained, with a few zero divisors among them.
	task automatic send_random(int unsigned ovf_pct);
		pair_t x;
		pair_t y;
		pair_t z;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		z = ($urandom_range(0, 3) == 0) ? rand_pair() : rand_scaled();
		y = ($urandom_range(0, 7) == 0) ? rand_scaled() : rand_pair();
		if (pick < ovf_pct) begin
			x = ($urandom_range(0, 1) == 0) ? rand_pair() : rand_scaled();
			if (pick < 2)
				z = '0;
		end else begin
			if (z == '0)
				z = pair_t'(1);
			x = rand_pair() % z;
		end
		send_division(x, y, z);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic test_directed();
		pair_t r;
		r = rand_pair();
		no_gaps = 1'b0;
		send_division('0, ALL_ONES, pair_t'(1));
		send_division('0, '0, pair_t'(1));
		send_division(ALL_ONES - 1, ALL_ONES, ALL_ONES);
		send_division('0, ALL_ONES, ALL_ONES);
		send_division(TOP_BIT - 1, ALL_ONES, TOP_BIT);
		send_division('0, r, '0);
		send_division(ALL_ONES, ALL_ONES, '0);
		send_division('0, '0, '0);
		send_division(pair_t'(12345) << 70, ALL_ONES, pair_t'(12345) << 70);
		send_division(ALL_ONES, '0, TOP_BIT);
		send_division({64'h0, {64{1'b1}}}, '0, {64'h1, 64'h0});
		send_division(pair_t'(5), '0, pair_t'(7));
		send_division(ALL_ONES, ALL_ONES, ALL_ONES);
		send_division('0, {{64{1'b1}}, 64'h0}, {64'h0, {64{1'b1}}});
		send_division({64{2'b01}}, {64{2'b10}}, {64{2'b10}});
		send_division(pair_t'(1), '0, pair_t'(2));
		send_division(r % (ALL_ONES >> 1), rand_pair(), ALL_ONES >> 1);
	endtask

	task automatic test_back_to_back();
		no_gaps = 1'b1;
		repeat (300) send_random(5);
	endtask

	task automatic test_random_gaps();
		for (int n = 0; n < 1200; n++) begin
			if (n % 64 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			send_random(8);
		end
	endtask

	task automatic test_overflow_mix();
		no_gaps = 1'b0;
		repeat (300) send_random(50);
	endtask

	task automatic check_field(string label, word_t want, word_t got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, label, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin : check_results
		div_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result transfer with nothing expected: expected none, actual %h %h",
					$time, quotient_hi, quotient_lo);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("quotient_hi", want.quo_hi, quotient_hi);
				check_field("quotient_lo", want.quo_lo, quotient_lo);
				check_field("remainder_hi", want.rem_hi, remainder_hi);
				check_field("remainder_lo", want.rem_lo, remainder_lo);
				check_field("overflow", word_t'(want.ovf), word_t'(overflow));
				checked_count++;
				if (want.ovf)
					overflow_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
					$display("[restoring_divider_256_by_128_core] ERROR");
					$finish;
				end
			end
		end
	end

	// Result side: after each transfer, hold ready low for a random number of cycles.
	initial begin : result_sink
		int unsigned stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		dividend_w3 = '0;
		dividend_w2 = '0;
		dividend_w1 = '0;
		dividend_w0 = '0;
		divisor_hi = '0;
		divisor_lo = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_back_to_back();
		wait_drained();
		test_random_gaps();
		wait_drained();
		test_overflow_mix();

		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (LATENCY + 8) @(posedge clk);

		$display("Sent %0d divisions (%0d with a zero divisor), checked %0d results, %0d flagged overflow.",
			sent_count, zero_divisor_count, checked_count, overflow_seen);
		$display("Covered back-to-back transfers, random gaps and stalls on both sides, and full drains.");
		if (mismatch_count == 0)
			$display("[restoring_divider_256_by_128_core] OK");
		else
			$display("[restoring_divider_256_by_128_core] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
